// ===== sv/rmmf_pkg.sv =====
// rmmf_pkg: shared types, widths and codes for the running median / mean filter
// no dependencies; imported by every module of the filter
`default_nettype none

package rmmf_pkg;

  // sample width and default window length
  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_DEF = 5;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // filter mode codes
  localparam logic MODE_MEDIAN = 1'b0;
  localparam logic MODE_MEAN   = 1'b1;

  // per-request status from the window store to the result stage
  typedef struct packed {
    logic use_window;   // window was full before this sample
  } win_status_t;

endpackage

`default_nettype wire

// ===== sv/rmmf_window.sv =====
// rmmf_window: ring window store, write pointer and fill count
// depends on rmmf_pkg; gives the window with the current sample placed in it
`default_nettype none

module rmmf_window #(
  parameter int WINDOW = rmmf_pkg::WINDOW_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         take,
  input  wire rmmf_pkg::sample_t                      sample,
  input  wire                                         restart,
  output rmmf_pkg::sample_t [WINDOW-1:0]              win_nxt,
  output rmmf_pkg::win_status_t                       status
);
  import rmmf_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);

  sample_t [WINDOW-1:0] store_r;
  logic [PTR_W-1:0]     wptr_r, wptr_nxt, ptr_eff;
  logic [FILL_W-1:0]    fill_r, fill_nxt, fill_eff;
  logic                 full;

  // restart clears pointer and fill count ahead of the write
  always_comb begin
    ptr_eff  = restart ? '0 : wptr_r;
    fill_eff = restart ? '0 : fill_r;
    full     = (fill_eff == FILL_W'(WINDOW));
    wptr_nxt = (ptr_eff == PTR_W'(WINDOW - 1)) ? '0 : ptr_eff + PTR_W'(1);
    fill_nxt = full ? fill_eff : fill_eff + FILL_W'(1);
  end

  // window as it stands once the sample is written
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      win_nxt[k] = (ptr_eff == PTR_W'(k)) ? sample : store_r[k];
    end
  end

  assign status.use_window = full;

  // sample store, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      store_r <= win_nxt;
    end
  end

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      fill_r <= '0;
    end else if (take) begin
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill count beyond window length");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= PTR_W'(WINDOW - 1))
    else $error("write pointer beyond window");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && restart |=> (fill_r == FILL_W'(1)) && (wptr_r == PTR_W'(1)))
    else $error("restart did not clear fill count and pointer");

endmodule

`default_nettype wire

// ===== sv/rmmf_median.sv =====
// rmmf_median: rank network picking the middle entry of the window
// depends on rmmf_pkg; ties are broken by store position
`default_nettype none

module rmmf_median #(
  parameter int WINDOW = rmmf_pkg::WINDOW_DEF
) (
  input  wire rmmf_pkg::sample_t [WINDOW-1:0] win,
  output rmmf_pkg::sample_t                   median
);
  import rmmf_pkg::*;

  localparam int RANK_W = $clog2(WINDOW);

  logic [RANK_W-1:0] rank [WINDOW];

  // rank of each entry: count of entries ordered before it
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((j != i) && ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // exactly one entry holds the middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RANK_W'(WINDOW / 2)) begin
        median = win[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rmmf_mean.sv =====
// rmmf_mean: window sum and truncated divide by the window length
// depends on rmmf_pkg; divide is a multiply by a rounded-up reciprocal
`default_nettype none

module rmmf_mean #(
  parameter int WINDOW = rmmf_pkg::WINDOW_DEF
) (
  input  wire rmmf_pkg::sample_t [WINDOW-1:0] win,
  output rmmf_pkg::sample_t                   mean
);
  import rmmf_pkg::*;

  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  // full-width sum of the window
  always_comb begin
    sum = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sum = sum + SUM_W'(win[i]);
    end
  end

  // floor(sum / WINDOW), exact for every sum below 2**SUM_W
  assign prod = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));
  assign mean = prod[SHIFT +: SAMPLE_W];

endmodule

`default_nettype wire

// ===== sv/running_median_mean_filter_top.sv =====
// running_median_mean_filter_top: running median / mean filter over a ring window
// depends on rmmf_pkg, rmmf_window, rmmf_median, rmmf_mean
//
//   channel  dir  ports                         contents
//   in_      in   tvalid tready tdata tuser     sample [15:0], restart [0]
//   out_     out  tvalid tready tdata tuser     filtered [15:0], window_full [0]
//   cfg_     in   wen wdata                     filter_mode [0]
//
// one request per cycle while out_tready keeps the result register draining; a request
// passes the input register, then the result register, with the rank network and the
// reciprocal multiplier between them
// rst_n is synchronous, active low; clears pointer, fill count, mode and valids
// a stalled result holds the output register and then the input register
`default_nettype none

module running_median_mean_filter_top #(
  parameter int WINDOW = rmmf_pkg::WINDOW_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // request channel
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [15:0]              in_tdata,   // [15:0] sample
  input  wire  [0:0]               in_tuser,   // [0] restart
  // result channel
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [15:0]              out_tdata,  // [15:0] filtered
  output logic [0:0]               out_tuser,  // [0] window_full
  // configuration
  input  wire                      cfg_wen,
  input  wire  [0:0]               cfg_wdata   // [0] filter_mode
);
  import rmmf_pkg::*;

  logic                 a_valid_r;
  sample_t              a_sample_r;
  logic                 a_restart_r;
  logic                 mode_r;
  logic                 out_valid_r;
  sample_t              out_filtered_r, out_filtered_nxt;
  logic                 out_full_r;
  logic                 a_fire, in_fire;
  sample_t [WINDOW-1:0] win_nxt;
  win_status_t          status;
  sample_t              median, mean;

  // handshake: stage A moves on when the result register is free or drains
  assign a_fire    = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_fire;
  assign in_fire   = in_tvalid && in_tready;

  // filter mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MEDIAN;
    end else if (cfg_wen) begin
      mode_r <= cfg_wdata[0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_sample_r  <= in_tdata;
      a_restart_r <= in_tuser[0];
    end
  end

  rmmf_window #(.WINDOW(WINDOW)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (a_fire),
    .sample  (a_sample_r),
    .restart (a_restart_r),
    .win_nxt (win_nxt),
    .status  (status)
  );

  rmmf_median #(.WINDOW(WINDOW)) u_median (
    .win    (win_nxt),
    .median (median)
  );

  rmmf_mean #(.WINDOW(WINDOW)) u_mean (
    .win  (win_nxt),
    .mean (mean)
  );

  // result select: raw sample while filling
  always_comb begin
    if (!status.use_window) begin
      out_filtered_nxt = a_sample_r;
    end else if (mode_r == MODE_MEAN) begin
      out_filtered_nxt = mean;
    end else begin
      out_filtered_nxt = median;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_filtered_r <= out_filtered_nxt;
      out_full_r     <= status.use_window;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_filtered_r;
  assign out_tuser[0] = out_full_r;

  // checks
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire |=> out_tvalid)
    else $error("stage A request lost before the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !a_fire)
    else $error("stalled result overwritten");

  a_restart_pass: assert property (@(posedge clk) disable iff (!rst_n)
    a_fire && a_restart_r |=> !out_full_r && (out_filtered_r == $past(a_sample_r)))
    else $error("restart request did not pass its sample through");

endmodule

`default_nettype wire
